[sv/assert_macros.svh]
// Assertion helpers for the checker assertion file.
// Every check is clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ERC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ERC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/icmp_erc_pkg.sv]
`default_nettype none
package icmp_erc_pkg;

  // Packet length handling
  localparam int MAX_PACKET_BYTES = 4096;
  localparam int BYTE_CAP         = (MAX_PACKET_BYTES < 8191) ? MAX_PACKET_BYTES : 8191;
  localparam int IP_MIN_BYTES     = 20;
  localparam int ICMP_HDR_BYTES   = 8;
  localparam int PAYLOAD_RESET    = 56;

  localparam int COUNT_W   = 13;
  localparam int HLEN_W    = 6;
  localparam int REGION_W  = COUNT_W + 1;
  localparam int SUM_W     = 17;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_EXPECTED_ID  = 2'd0,
    CFG_EXPECTED_SEQ = 2'd1,
    CFG_PAY_LEN      = 2'd2
  } cfg_idx_e;

  // Result codes
  typedef enum logic [3:0] {
    ST_VALID         = 4'd0,
    ST_SHORT_IP      = 4'd1,
    ST_SHORT_ICMP    = 4'd2,
    ST_BAD_TYPE      = 4'd3,
    ST_BAD_ID        = 4'd4,
    ST_BAD_SEQ       = 4'd5,
    ST_BAD_CODE      = 4'd6,
    ST_SHORT_PAYLOAD = 4'd7,
    ST_BAD_CHECKSUM  = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [3:0] status;
    logic       echo_hit;
  } out_t;

  typedef struct packed {
    logic [15:0]        expected_id;
    logic [15:0]        expected_seq;
    logic [COUNT_W-1:0] pay_len;
  } cfg_t;

endpackage
`default_nettype wire

[sv/icmp_erc_core.sv]
`default_nettype none
module icmp_erc_core import icmp_erc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  word_i,
  input  wire logic step_i,
  input  wire cfg_t cfg_i,
  output out_t      result_o
);

  logic [COUNT_W-1:0] count_q, count_d;
  logic [HLEN_W-1:0]  hlen_q, hlen_d;
  logic [7:0]         type_q, type_d;
  logic [7:0]         code_q, code_d;
  logic [15:0]        id_q, id_d;
  logic [15:0]        seq_q, seq_d;
  logic [15:0]        rxsum_q, rxsum_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [7:0]         hbyte_q, hbyte_d;

  logic [COUNT_W-1:0]  offs;
  logic [COUNT_W-1:0]  rem;
  logic [REGION_W-1:0] region;
  logic [SUM_W-1:0]    sum_chk;
  logic                short_icmp;

  // Ones-complement add of one 16-bit word with end-around carry
  function automatic logic [SUM_W-1:0] add_word(input logic [SUM_W-1:0] acc,
                                                input logic [15:0] w);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {2'b00, w};
    return SUM_W'({2'b00, s[15:0]} + {16'h0000, s[SUM_W:16]});
  endfunction

  assign region = REGION_W'(ICMP_HDR_BYTES) + {1'b0, cfg_i.pay_len};

  // Fold the byte into the packet state
  always_comb begin
    count_d = count_q;
    hlen_d  = hlen_q;
    type_d  = type_q;
    code_d  = code_q;
    id_d    = id_q;
    seq_d   = seq_q;
    rxsum_d = rxsum_q;
    sum_d   = sum_q;
    hbyte_d = hbyte_q;
    offs    = '0;
    if (count_q < COUNT_W'(BYTE_CAP)) begin
      count_d = count_q + COUNT_W'(1);
      if (count_q == '0) begin
        hlen_d = {word_i.data_byte[3:0], 2'b00};
      end
      if (count_q >= COUNT_W'(hlen_d)) begin
        offs = count_q - COUNT_W'(hlen_d);
        case (offs)
          COUNT_W'(0): type_d = word_i.data_byte;
          COUNT_W'(1): code_d = word_i.data_byte;
          COUNT_W'(2): rxsum_d[15:8] = word_i.data_byte;
          COUNT_W'(3): rxsum_d[7:0]  = word_i.data_byte;
          COUNT_W'(4): id_d[15:8]    = word_i.data_byte;
          COUNT_W'(5): id_d[7:0]     = word_i.data_byte;
          COUNT_W'(6): seq_d[15:8]   = word_i.data_byte;
          COUNT_W'(7): seq_d[7:0]    = word_i.data_byte;
          default: ;
        endcase
        // Sum the checksum region, skipping the checksum field itself
        if (({1'b0, offs} < region) && (offs != COUNT_W'(2)) && (offs != COUNT_W'(3))) begin
          if (!offs[0]) begin
            hbyte_d = word_i.data_byte;
          end else begin
            sum_d = add_word(sum_q, {hbyte_q, word_i.data_byte});
          end
        end
      end
    end
  end

  // Judge the packet on its last byte.
  // With an odd region the padded word is added to the old sum: whenever the
  // checksum is actually judged, this byte added no word of its own.
  always_comb begin
    short_icmp = (COUNT_W'(hlen_d) > count_d);
    rem        = count_d - COUNT_W'(hlen_d);
    if (rem < COUNT_W'(ICMP_HDR_BYTES)) begin
      short_icmp = 1'b1;
    end
    sum_chk = region[0] ? add_word(sum_q, {hbyte_d, 8'h00}) : sum_d;

    result_o.echo_hit = 1'b0;
    if (count_d < COUNT_W'(IP_MIN_BYTES)) begin
      result_o.status = ST_SHORT_IP;
    end else if (short_icmp) begin
      result_o.status = ST_SHORT_ICMP;
    end else if (type_d != 8'h00) begin
      result_o.status = ST_BAD_TYPE;
    end else if (id_d != cfg_i.expected_id) begin
      result_o.status = ST_BAD_ID;
    end else if (seq_d != cfg_i.expected_seq) begin
      result_o.status = ST_BAD_SEQ;
    end else if (code_d != 8'h00) begin
      result_o.status = ST_BAD_CODE;
    end else begin
      result_o.echo_hit = 1'b1;
      if ({1'b0, rem} < region) begin
        result_o.status = ST_SHORT_PAYLOAD;
      end else if (~sum_chk[15:0] != rxsum_d) begin
        result_o.status = ST_BAD_CHECKSUM;
      end else begin
        result_o.status = ST_VALID;
      end
    end
  end

  // Advance the packet state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hlen_q  <= '0;
      type_q  <= '0;
      code_q  <= '0;
      id_q    <= '0;
      seq_q   <= '0;
      rxsum_q <= '0;
      sum_q   <= '0;
      hbyte_q <= '0;
    end else if (step_i) begin
      if (word_i.last) begin
        count_q <= '0;
        hlen_q  <= '0;
        type_q  <= '0;
        code_q  <= '0;
        id_q    <= '0;
        seq_q   <= '0;
        rxsum_q <= '0;
        sum_q   <= '0;
        hbyte_q <= '0;
      end else begin
        count_q <= count_d;
        hlen_q  <= hlen_d;
        type_q  <= type_d;
        code_q  <= code_d;
        id_q    <= id_d;
        seq_q   <= seq_d;
        rxsum_q <= rxsum_d;
        sum_q   <= sum_d;
        hbyte_q <= hbyte_d;
      end
    end
  end

endmodule
`default_nettype wire

[sv/icmp_echo_reply_checker.sv]
// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+-----------------------------
// in       | input     | in_valid_i / in_ready_o    | in_t: data_byte, last
// out      | output    | out_valid_o / out_ready_i  | out_t: status, echo_hit
// cfg      | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One byte per cycle unless stalled; per-byte work is one checksum add and compares.
// After the last byte is accepted it passes the input register, then the result
// register, whose valid flag drives out_valid_o.
// Reset clears all packet state and loads the register defaults; no clearing pass.
// The input stalls only while a last byte waits in the input register on a full result.
`default_nettype none
module icmp_echo_reply_checker import icmp_erc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_t         in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_t             out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic s1_valid_q;
  in_t  s1_word_q;
  logic out_valid_q;
  out_t out_q;
  logic s1_adv;
  out_t result;

  // A byte leaves the input register unless it is a last byte facing a full output
  assign s1_adv     = s1_valid_q && (!s1_word_q.last || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_id  <= '0;
      cfg_q.expected_seq <= '0;
      cfg_q.pay_len      <= COUNT_W'(PAYLOAD_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXPECTED_ID:  cfg_q.expected_id  <= cfg_wdata_i;
        CFG_EXPECTED_SEQ: cfg_q.expected_seq <= cfg_wdata_i;
        CFG_PAY_LEN:      cfg_q.pay_len      <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  icmp_erc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (s1_word_q),
    .step_i   (s1_adv),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Track valid flags of the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_word_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_word_q <= in_i;
    end
    if (s1_adv && s1_word_q.last) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

[sv/icmp_erc_sva.sv]
`default_nettype none
`include "assert_macros.svh"
module icmp_erc_sva import icmp_erc_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire in_t         in_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire out_t        out_o
);

  // Result word waits until taken
  `ERC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o), "result dropped or changed while stalled")

  // Status codes stay within the defined set
  `ERC_ASSERT_NOW(a_status_range, out_valid_o, out_o.status <= ST_BAD_CHECKSUM, "status code out of range")

  // Match flag agrees with the status code
  `ERC_ASSERT_NOW(a_match_code, out_valid_o, out_o.echo_hit == ((out_o.status == ST_VALID) || (out_o.status == ST_SHORT_PAYLOAD) || (out_o.status == ST_BAD_CHECKSUM)), "match flag inconsistent with status")

  // Input stays open right after a non-last byte is taken
  `ERC_ASSERT_NEXT(a_no_stall, in_valid_i && in_ready_o && !in_i.last, in_ready_o, "input stalled behind a non-last byte")

endmodule

bind icmp_echo_reply_checker icmp_erc_sva u_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
`default_nettype wire
